FILE: rtl/core/cltok_pkg.sv
package cltok_pkg;

	localparam int unsigned OFFSET_BITS   = 20;
	localparam int unsigned POSITION_BITS = 16;
	localparam int unsigned LENGTH_BITS   = OFFSET_BITS + 1;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]               token_kind;
		logic [7:0]               punct_char;
		logic [2:0]               error_code;
		logic [OFFSET_BITS-1:0]   start_offset;
		logic [LENGTH_BITS-1:0]   token_length;
		logic [POSITION_BITS-1:0] line_number;
		logic [POSITION_BITS-1:0] column_number;
		logic                     last;
	} token_item_t;

	typedef struct packed {
		logic [1:0]  count;
		token_item_t first;
		token_item_t second;
	} token_push_t;

endpackage

FILE: rtl/core/cltok_scan.sv
module cltok_scan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  cltok_pkg::byte_item_t  item,
	output cltok_pkg::token_push_t push
);
	import cltok_pkg::*;

	localparam logic [3:0] M_IDLE     = 4'd0;
	localparam logic [3:0] M_IDENT    = 4'd1;
	localparam logic [3:0] M_NUMBER   = 4'd2;
	localparam logic [3:0] M_STRING   = 4'd3;
	localparam logic [3:0] M_SLASH    = 4'd4;
	localparam logic [3:0] M_COLON    = 4'd5;
	localparam logic [3:0] M_LINECOM  = 4'd6;
	localparam logic [3:0] M_BLOCKCOM = 4'd7;
	localparam logic [3:0] M_ERROR    = 4'd8;

	localparam logic [1:0] E_NORMAL    = 2'd0;
	localparam logic [1:0] E_BACKSLASH = 2'd1;
	localparam logic [1:0] E_CR        = 2'd2;

	localparam logic [2:0] K_END    = 3'd0;
	localparam logic [2:0] K_IDENT  = 3'd1;
	localparam logic [2:0] K_NUMBER = 3'd2;
	localparam logic [2:0] K_STRING = 3'd3;
	localparam logic [2:0] K_DCOLON = 3'd4;
	localparam logic [2:0] K_PUNCT  = 3'd5;
	localparam logic [2:0] K_ERROR  = 3'd6;

	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_EOT_COMMENT = 3'd1;
	localparam logic [2:0] ERR_EOT_STRING  = 3'd2;
	localparam logic [2:0] ERR_NEWLINE     = 3'd3;
	localparam logic [2:0] ERR_INVALID     = 3'd4;

	localparam logic [7:0] C_TAB    = 8'd9;
	localparam logic [7:0] C_LF     = 8'd10;
	localparam logic [7:0] C_CR     = 8'd13;
	localparam logic [7:0] C_SPACE  = 8'd32;
	localparam logic [7:0] C_DEL    = 8'd127;
	localparam logic [7:0] C_QUOTE  = 8'h22;
	localparam logic [7:0] C_STAR   = 8'h2a;
	localparam logic [7:0] C_SLASH  = 8'h2f;
	localparam logic [7:0] C_COLON  = 8'h3a;
	localparam logic [7:0] C_BSLASH = 8'h5c;
	localparam logic [7:0] C_UNDER  = 8'h5f;
	localparam logic [7:0] C_NUL    = 8'd0;

	localparam logic [OFFSET_BITS-1:0]   OFF_MAX  = {OFFSET_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
	localparam logic [LENGTH_BITS-1:0]   LEN_ZERO = '0;
	localparam logic [LENGTH_BITS-1:0]   LEN_ONE  = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0]   LEN_TWO  = LENGTH_BITS'(2);

	function automatic token_item_t make_token(
		input logic [2:0]               kind,
		input logic [7:0]               pch,
		input logic [2:0]               err,
		input logic [OFFSET_BITS-1:0]   off,
		input logic [LENGTH_BITS-1:0]   len,
		input logic [POSITION_BITS-1:0] line,
		input logic [POSITION_BITS-1:0] col
	);
		token_item_t t;
		t.token_kind    = kind;
		t.punct_char    = pch;
		t.error_code    = err;
		t.start_offset  = off;
		t.token_length  = len;
		t.line_number   = line;
		t.column_number = col;
		t.last          = 1'b0;
		return t;
	endfunction

	logic [3:0]               mode_q, mode_d;
	logic [1:0]               esc_q, esc_d;
	logic                     star_q, star_d;
	logic [OFFSET_BITS-1:0]   off_q, off_d;
	logic [POSITION_BITS-1:0] line_q, line_d;
	logic [POSITION_BITS-1:0] col_q, col_d;
	logic [OFFSET_BITS-1:0]   tstart_off_q;
	logic [POSITION_BITS-1:0] tstart_line_q;
	logic [POSITION_BITS-1:0] tstart_col_q;

	logic [7:0]             c;
	logic                   is_ws, is_alpha, is_digit, is_punct;
	logic [3:0]             bt_mode;
	logic                   bt_mark, bt_esc_clear, bt_v;
	token_item_t            bt_tok;
	logic                   mark, clear;
	logic                   a_v, b_v;
	token_item_t            a_tok, b_tok;
	logic [LENGTH_BITS-1:0] pend_len, str_len;
	token_item_t            err_tok_nl;

	assign c        = item.char_code;
	assign is_ws    = (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
	assign is_alpha = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
		(c == C_UNDER);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign is_punct = (c > C_SPACE) && (c < C_DEL);
	assign pend_len = {1'b0, off_q} - {1'b0, tstart_off_q};
	assign str_len  = pend_len + LEN_ONE;
	assign err_tok_nl = make_token(K_ERROR, C_NUL, ERR_NEWLINE, off_q, LEN_ZERO, line_q,
		col_q);

	always_comb begin
		bt_mode      = M_IDLE;
		bt_mark      = 1'b0;
		bt_esc_clear = 1'b0;
		bt_v         = 1'b0;
		bt_tok       = make_token(K_PUNCT, c, ERR_NONE, off_q, LEN_ONE, line_q, col_q);
		priority if (is_ws) begin
			bt_mode = M_IDLE;
		end else if (c == C_SLASH) begin
			bt_mark = 1'b1;
			bt_mode = M_SLASH;
		end else if (is_alpha) begin
			bt_mark = 1'b1;
			bt_mode = M_IDENT;
		end else if (is_digit) begin
			bt_mark = 1'b1;
			bt_mode = M_NUMBER;
		end else if (c == C_QUOTE) begin
			bt_mark      = 1'b1;
			bt_mode      = M_STRING;
			bt_esc_clear = 1'b1;
		end else if (c == C_COLON) begin
			bt_mark = 1'b1;
			bt_mode = M_COLON;
		end else if (is_punct) begin
			bt_v = 1'b1;
		end else begin
			bt_v    = 1'b1;
			bt_tok  = make_token(K_ERROR, C_NUL, ERR_INVALID, off_q, LEN_ZERO, line_q, col_q);
			bt_mode = M_ERROR;
		end
	end

	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		star_d = star_q;
		off_d  = off_q;
		line_d = line_q;
		col_d  = col_q;
		mark   = 1'b0;
		clear  = 1'b0;
		a_v    = 1'b0;
		b_v    = 1'b0;
		a_tok  = bt_tok;
		b_tok  = bt_tok;
		if (item.end_of_text) begin
			clear = 1'b1;
			b_v   = 1'b1;
			b_tok = make_token(K_END, C_NUL, ERR_NONE, off_q, LEN_ZERO, line_q, col_q);
			unique case (mode_q)
				M_IDENT, M_NUMBER: begin
					a_v   = 1'b1;
					a_tok = make_token((mode_q == M_IDENT) ? K_IDENT : K_NUMBER, C_NUL,
						ERR_NONE, tstart_off_q, pend_len, tstart_line_q, tstart_col_q);
				end
				M_SLASH, M_COLON: begin
					a_v   = 1'b1;
					a_tok = make_token(K_PUNCT, (mode_q == M_SLASH) ? C_SLASH : C_COLON,
						ERR_NONE, tstart_off_q, LEN_ONE, tstart_line_q, tstart_col_q);
				end
				M_STRING: begin
					a_v   = 1'b1;
					b_v   = 1'b0;
					a_tok = make_token(K_ERROR, C_NUL, ERR_EOT_STRING, off_q, LEN_ZERO,
						line_q, col_q);
				end
				M_BLOCKCOM: begin
					a_v   = 1'b1;
					b_v   = 1'b0;
					a_tok = make_token(K_ERROR, C_NUL, ERR_EOT_COMMENT, off_q, LEN_ZERO,
						line_q, col_q);
				end
				default: begin
					a_v = 1'b0;
				end
			endcase
		end else begin
			unique case (mode_q)
				M_IDLE: begin
					mode_d = bt_mode;
					mark   = bt_mark;
					if (bt_esc_clear) begin
						esc_d = E_NORMAL;
					end
					a_v   = bt_v;
					a_tok = bt_tok;
				end
				M_IDENT, M_NUMBER: begin
					if (!(is_alpha || is_digit)) begin
						a_v   = 1'b1;
						a_tok = make_token((mode_q == M_IDENT) ? K_IDENT : K_NUMBER, C_NUL,
							ERR_NONE, tstart_off_q, pend_len, tstart_line_q, tstart_col_q);
						mode_d = bt_mode;
						mark   = bt_mark;
						if (bt_esc_clear) begin
							esc_d = E_NORMAL;
						end
						b_v = bt_v;
					end
				end
				M_STRING: begin
					priority if (c == C_QUOTE) begin
						esc_d = E_NORMAL;
						if (esc_q != E_BACKSLASH) begin
							a_v    = 1'b1;
							a_tok  = make_token(K_STRING, C_NUL, ERR_NONE, tstart_off_q,
								str_len, tstart_line_q, tstart_col_q);
							mode_d = M_IDLE;
						end
					end else if (c == C_BSLASH) begin
						esc_d = (esc_q == E_BACKSLASH) ? E_NORMAL : E_BACKSLASH;
					end else if (c == C_LF) begin
						esc_d = E_NORMAL;
						if (esc_q == E_NORMAL) begin
							a_v    = 1'b1;
							a_tok  = err_tok_nl;
							mode_d = M_ERROR;
						end
					end else if (c == C_CR) begin
						if (esc_q == E_BACKSLASH) begin
							esc_d = E_CR;
						end
					end else begin
						esc_d = E_NORMAL;
					end
				end
				M_SLASH, M_COLON: begin
					if (mode_q == M_SLASH && c == C_SLASH) begin
						mode_d = M_LINECOM;
					end else if (mode_q == M_SLASH && c == C_STAR) begin
						mode_d = M_BLOCKCOM;
						star_d = 1'b0;
					end else if (mode_q == M_COLON && c == C_COLON) begin
						a_v    = 1'b1;
						a_tok  = make_token(K_DCOLON, C_NUL, ERR_NONE, tstart_off_q, LEN_TWO,
							tstart_line_q, tstart_col_q);
						mode_d = M_IDLE;
					end else begin
						a_v   = 1'b1;
						a_tok = make_token(K_PUNCT, (mode_q == M_SLASH) ? C_SLASH : C_COLON,
							ERR_NONE, tstart_off_q, LEN_ONE, tstart_line_q, tstart_col_q);
						mode_d = bt_mode;
						mark   = bt_mark;
						if (bt_esc_clear) begin
							esc_d = E_NORMAL;
						end
						b_v = bt_v;
					end
				end
				M_LINECOM: begin
					if (c == C_LF) begin
						mode_d = M_IDLE;
					end
				end
				M_BLOCKCOM: begin
					if (star_q && c == C_SLASH) begin
						mode_d = M_IDLE;
						star_d = 1'b0;
					end else begin
						star_d = (c == C_STAR);
					end
				end
				default: begin
					mode_d = M_ERROR;
				end
			endcase
			if (off_q != OFF_MAX) begin
				off_d = off_q + OFFSET_BITS'(1);
			end
			if (c == C_LF) begin
				col_d = POS_ONE;
				if (line_q != POS_MAX) begin
					line_d = line_q + POS_ONE;
				end
			end else if (col_q != POS_MAX) begin
				col_d = col_q + POS_ONE;
			end
		end
	end

	always_comb begin
		push.count       = fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
		push.first       = a_v ? a_tok : b_tok;
		push.first.last  = !(a_v && b_v);
		push.second      = b_tok;
		push.second.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_IDLE;
			esc_q         <= E_NORMAL;
			star_q        <= 1'b0;
			off_q         <= '0;
			line_q        <= POS_ONE;
			col_q         <= POS_ONE;
			tstart_off_q  <= '0;
			tstart_line_q <= POS_ONE;
			tstart_col_q  <= POS_ONE;
		end else if (fire) begin
			if (clear) begin
				mode_q        <= M_IDLE;
				esc_q         <= E_NORMAL;
				star_q        <= 1'b0;
				off_q         <= '0;
				line_q        <= POS_ONE;
				col_q         <= POS_ONE;
				tstart_off_q  <= '0;
				tstart_line_q <= POS_ONE;
				tstart_col_q  <= POS_ONE;
			end else begin
				mode_q <= mode_d;
				esc_q  <= esc_d;
				star_q <= star_d;
				off_q  <= off_d;
				line_q <= line_d;
				col_q  <= col_d;
				if (mark) begin
					tstart_off_q  <= off_q;
					tstart_line_q <= line_q;
					tstart_col_q  <= col_q;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two results from one byte");
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> !push.first.last && push.second.last)
		else $error("last flag misplaced on result pair");
	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_text |=> mode_q == M_IDLE && off_q == '0 && line_q == POS_ONE &&
		col_q == POS_ONE)
		else $error("end of text did not restart the scanner");
`endif

endmodule

FILE: rtl/core/cltok_outq.sv
module cltok_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cltok_pkg::token_push_t push,
	output logic                   room,
	output logic                   valid,
	input  logic                   stall,
	output cltok_pkg::token_item_t item
);
	import cltok_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;

	token_item_t       entry_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q, rptr_q, wnext;
	logic [CNT_W-1:0]  cnt_q;
	logic              pop;

	assign pop   = valid && !stall;
	assign wnext = wptr_q + PTR_W'(1);
	assign valid = (cnt_q != '0);
	assign room  = (cnt_q <= CNT_W'(DEPTH - 2));
	assign item  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wnext] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + PTR_W'(push.count);
			rptr_q <= rptr_q + PTR_W'(pop);
			cnt_q  <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> cnt_q <= CNT_W'(DEPTH - 2))
		else $error("push into result queue without room");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> cnt_q >= $past(cnt_q) && rptr_q == $past(rptr_q))
		else $error("result dropped while stalled");
`endif

endmodule

FILE: rtl/core/c_like_source_tokenizer_core.sv
// Path: input register, combinational scanner, then the four-entry result queue to the output.
// Throughput: one byte per cycle while the queue has room; a byte that closes a token and opens a
// punctuation or error result, or an end of text that flushes a pending token, produces two
// transactions, which the result queue drains at one a cycle while token_stall is low.
// Reset: arst_n clears the scanner to between tokens at offset 0, line 1, column 1, and empties
// the input register and the result queue.
module c_like_source_tokenizer_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  cltok_pkg::byte_item_t  byte_item,
	output logic                   token_valid,
	input  logic                   token_stall,
	output cltok_pkg::token_item_t token_item
);
	import cltok_pkg::*;

	logic        valid_s1;
	byte_item_t  item_s1;
	logic        room, advance, accept;
	token_push_t push;

	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	cltok_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.push   (push)
	);

	cltok_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (token_valid),
		.stall  (token_stall),
		.item   (token_item)
	);

endmodule
